// ===== src/box_blur_clipped_window_core_defines.svh =====
// ----------------------------------------------------------------------------
// box blur core assertion macros
// shared assertion helpers, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_CLIPPED_WINDOW_CORE_DEFINES_SVH
`define BOX_BLUR_CLIPPED_WINDOW_CORE_DEFINES_SVH

// plain property check
`define BBCW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the next cycle
`define BBCW_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== src/bbcw_pkg.sv =====
// ----------------------------------------------------------------------------
// box blur core package
// sequencer states, command codes and register indexes
// ----------------------------------------------------------------------------
package bbcw_pkg;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_SUM   = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam int NUM_CH = 3;

endpackage

// ===== src/box_blur_clipped_window_core.sv =====
// ----------------------------------------------------------------------------
// box blur clipped window core
// streaming rgb box blur with a clipped square window and a line store
// ----------------------------------------------------------------------------
// Pixels come in raster order on the slave stream (tuser 0) and blurred pixels
// leave in raster order on the master stream, tlast marking the last pixel of
// the frame; a tuser 1 transaction drains one pending output after the frame.
// One input pixel transaction releases up to 8 outputs; each output sums the N
// window pixels inside the image (at most (2R+1)^2, R being kernel_radius),
// then runs a divider of width SW (8 + clog2((2*MAX_RADIUS+1)^2 + 1)), then
// waits for the master stream to take it. No new input is taken until then.
// The window is summed one line store entry per cycle through the single
// read port, then a restoring divider per channel, sharing the divisor, makes
// one quotient bit per cycle for all three channels.
// The line store holds 2*MAX_RADIUS+1 rows of MAX_WIDTH entries and needs no
// clearing after reset. Writing any register restarts the frame.
`include "box_blur_clipped_window_core_defines.svh"

module box_blur_clipped_window_core #(
  parameter int MAX_RADIUS = 7,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red, in_green, in_blue
  input  logic        s_tuser,   // command
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_col, out_row, out_red, out_green, out_blue
  output logic        m_tlast,   // frame_done
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bbcw_pkg::*;

  localparam int RING    = 2 * MAX_RADIUS + 1;
  localparam int SLW     = $clog2(RING);
  localparam int CLW     = $clog2(MAX_WIDTH);
  localparam int RLW     = $clog2(MAX_HEIGHT);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int RADW    = $clog2(MAX_RADIUS + 1);
  localparam int DEPTH   = RING * MAX_WIDTH;
  localparam int AW      = $clog2(DEPTH);
  localparam int DW      = $clog2(RING + 1);
  localparam int CNT_MAX = RING * RING;
  localparam int CW      = $clog2(CNT_MAX + 1);
  localparam int SW      = 8 + CW;
  localparam int STW     = $clog2(SW + 1);

  // configuration registers
  logic [RADW-1:0] radius;
  logic [WW-1:0]   img_w;
  logic [HW-1:0]   img_h;

  // positions
  logic [RLW-1:0] arrive_row, emit_row;
  logic [CLW-1:0] arrive_col, emit_col;
  logic [SLW-1:0] arrive_slot, emit_slot;
  logic           finished;
  logic [3:0]     left;

  state_t state;

  // window walk
  logic [RLW-1:0] y_cur, y_end;
  logic [CLW-1:0] x_cur, x_beg, x_end;
  logic [SLW-1:0] ys;
  logic [DW-1:0]  dim_r, dim_c;
  logic           pend;
  logic [SW-1:0]  acc [NUM_CH];
  logic [CW-1:0]  cnt;
  logic [SW-1:0]  sh  [NUM_CH];
  logic [CW-1:0]  rem [NUM_CH];
  logic [STW-1:0] step;

  // line store
  logic [23:0]   mem [DEPTH];
  logic [23:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    end
    rdata <= mem[raddr];
  end

  assign waddr = AW'(AW'(arrive_slot) * AW'(MAX_WIDTH) + AW'(arrive_col));
  assign raddr = AW'(AW'(ys) * AW'(MAX_WIDTH) + AW'(x_cur));

  // handshake
  logic s_acc, m_acc, cfg_wr, drop;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign s_acc    = s_tvalid && s_tready;
  assign m_acc    = m_tvalid && m_tready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign we       = s_acc && (s_tuser == CMD_PIXEL) && !drop;

  // window bounds and readiness of the next output
  logic [RLW:0]   nr_raw, h_last;
  logic [CLW:0]   nc_raw, w_last;
  logic [RLW-1:0] r0, r1;
  logic [CLW-1:0] c0, c1;
  logic [RADW-1:0] dr;
  logic [SLW:0]   slot_w;
  logic [SLW-1:0] slot0;
  logic           arr_zero, emit_zero, ready;

  always_comb begin
    nr_raw    = (RLW+1)'(emit_row) + (RLW+1)'(radius);
    nc_raw    = (CLW+1)'(emit_col) + (CLW+1)'(radius);
    h_last    = (RLW+1)'(img_h) - 1'b1;
    w_last    = (CLW+1)'(img_w) - 1'b1;
    r1        = RLW'(nr_raw > h_last ? h_last : nr_raw);
    c1        = CLW'(nc_raw > w_last ? w_last : nc_raw);
    r0        = (emit_row >= RLW'(radius)) ? emit_row - RLW'(radius) : '0;
    c0        = (emit_col >= CLW'(radius)) ? emit_col - CLW'(radius) : '0;
    dr        = RADW'(emit_row - r0);
    slot_w    = ((SLW+1)'(emit_slot) >= (SLW+1)'(dr)) ?
                (SLW+1)'(emit_slot) - (SLW+1)'(dr) :
                (SLW+1)'(emit_slot) + (SLW+1)'(RING) - (SLW+1)'(dr);
    slot0     = SLW'(slot_w);
    arr_zero  = (arrive_row == '0) && (arrive_col == '0);
    emit_zero = (emit_row == '0) && (emit_col == '0);
    drop      = arr_zero && !emit_zero;
    if (finished) begin
      ready = 1'b1;
    end else if (arr_zero) begin
      ready = !emit_zero;
    end else begin
      ready = (arrive_row > r1) || ((arrive_row == r1) && (arrive_col > c1));
    end
  end

  // divider step for all channels
  logic [CW:0]   trial [NUM_CH];
  logic [SW-1:0] sum_fin [NUM_CH];
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      trial[k]   = {rem[k], sh[k][SW-1]};
      sum_fin[k] = acc[k] + (pend ? SW'(rdata[23-8*k -: 8]) : '0);
    end
  end

  // register saturation
  logic [2:0]  cfg_r3;
  logic [10:0] cfg_v11;
  always_comb begin
    cfg_r3  = pwdata[2:0];
    cfg_v11 = (pwdata[10:0] == '0) ? 11'd1 : pwdata[10:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      radius      <= RADW'(1);
      img_w       <= WW'(MAX_WIDTH < 1024 ? MAX_WIDTH : 1024);
      img_h       <= HW'(MAX_HEIGHT < 1024 ? MAX_HEIGHT : 1024);
      arrive_row  <= '0;
      arrive_col  <= '0;
      arrive_slot <= '0;
      emit_row    <= '0;
      emit_col    <= '0;
      emit_slot   <= '0;
      finished    <= 1'b0;
      left        <= '0;
      pend        <= 1'b0;
      step        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_acc) begin
            finished <= 1'b0;
            if (s_tuser == CMD_PIXEL) begin
              if (!drop) begin
                left  <= 4'd8;
                state <= ST_CHECK;
                if ((WW)'(arrive_col) + 1'b1 >= img_w) begin
                  arrive_col <= '0;
                  if ((HW)'(arrive_row) + 1'b1 >= img_h) begin
                    arrive_row  <= '0;
                    arrive_slot <= '0;
                    finished    <= 1'b1;
                  end else begin
                    arrive_row  <= arrive_row + 1'b1;
                    arrive_slot <= (arrive_slot == SLW'(RING - 1)) ? '0 :
                                   arrive_slot + 1'b1;
                  end
                end else begin
                  arrive_col <= arrive_col + 1'b1;
                end
              end
            end else begin
              left  <= 4'd1;
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if ((left != '0) && ready) begin
            y_cur <= r0;
            y_end <= r1;
            x_cur <= c0;
            x_beg <= c0;
            x_end <= c1;
            ys    <= slot0;
            dim_r <= DW'(r1 - r0) + 1'b1;
            dim_c <= DW'(c1 - c0) + 1'b1;
            pend  <= 1'b0;
            for (int k = 0; k < NUM_CH; k++) acc[k] <= '0;
            state <= ST_SUM;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SUM: begin
          pend <= 1'b1;
          for (int k = 0; k < NUM_CH; k++) acc[k] <= sum_fin[k];
          if (x_cur == x_end) begin
            x_cur <= x_beg;
            if (y_cur == y_end) begin
              state <= ST_FLUSH;
            end else begin
              y_cur <= y_cur + 1'b1;
              ys    <= (ys == SLW'(RING - 1)) ? '0 : ys + 1'b1;
            end
          end else begin
            x_cur <= x_cur + 1'b1;
          end
        end
        ST_FLUSH: begin
          pend <= 1'b0;
          cnt  <= CW'((2*DW)'(dim_r) * (2*DW)'(dim_c));
          for (int k = 0; k < NUM_CH; k++) begin
            sh[k]  <= sum_fin[k];
            rem[k] <= '0;
          end
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          for (int k = 0; k < NUM_CH; k++) begin
            if (trial[k] >= {1'b0, cnt}) begin
              rem[k] <= CW'(trial[k] - {1'b0, cnt});
              sh[k]  <= {sh[k][SW-2:0], 1'b1};
            end else begin
              rem[k] <= CW'(trial[k]);
              sh[k]  <= {sh[k][SW-2:0], 1'b0};
            end
          end
          step <= step + 1'b1;
          if (step == STW'(SW - 1)) state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_acc) begin
            left  <= left - 1'b1;
            state <= ST_CHECK;
            if ((WW)'(emit_col) + 1'b1 >= img_w) begin
              emit_col <= '0;
              if ((HW)'(emit_row) + 1'b1 >= img_h) begin
                emit_row  <= '0;
                emit_slot <= '0;
                state     <= ST_IDLE;
              end else begin
                emit_row  <= emit_row + 1'b1;
                emit_slot <= (emit_slot == SLW'(RING - 1)) ? '0 : emit_slot + 1'b1;
              end
            end else begin
              emit_col <= emit_col + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase

      // register write restarts the frame
      if (cfg_wr && (paddr[3:2] != 2'd3)) begin
        unique case (paddr[3:2])
          REG_RADIUS: radius <= (32'(cfg_r3) > MAX_RADIUS) ? RADW'(MAX_RADIUS) : RADW'(cfg_r3);
          REG_WIDTH:  img_w  <= (32'(cfg_v11) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_v11);
          REG_HEIGHT: img_h  <= (32'(cfg_v11) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_v11);
          default: ;
        endcase
        arrive_row  <= '0;
        arrive_col  <= '0;
        arrive_slot <= '0;
        emit_row    <= '0;
        emit_col    <= '0;
        emit_slot   <= '0;
      end
    end
  end

  // register read
  always_comb begin
    unique case (paddr[3:2])
      REG_RADIUS: prdata = 32'(radius);
      REG_WIDTH:  prdata = 32'(img_w);
      REG_HEIGHT: prdata = 32'(img_h);
      default:    prdata = '0;
    endcase
  end

  // result
  assign m_tdata = {4'd0, 10'(emit_col), 10'(emit_row),
                    sh[2][7:0], sh[1][7:0], sh[0][7:0]};
  assign m_tlast = ((HW)'(emit_row) == img_h - 1'b1) && ((WW)'(emit_col) == img_w - 1'b1);

  // checks
  `BBCW_ASSERT(a_one_side, !(s_tready && m_tvalid), "both stream sides active")
  `BBCW_ASSERT(a_step_range, (state != ST_DIV) || (step < STW'(SW)), "divider overran")
  `BBCW_ASSERT_NEXT(a_frame_end, m_tvalid && m_tready && m_tlast && !cfg_wr, s_tready, "no idle after frame end")
  `BBCW_ASSERT(a_left_bound, left <= 4'd8, "result budget overflow")

endmodule
